// ===== rtl/error_rate_clock_governor_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the clock governor
// Shared property wrappers on clk_i with reset disable.
// ---------------------------------------------------------------------------
`ifndef ERROR_RATE_CLOCK_GOVERNOR_CORE_MACROS_SVH
`define ERROR_RATE_CLOCK_GOVERNOR_CORE_MACROS_SVH

// same-cycle implication
`define ERCG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ERCG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ercg_pkg.sv =====
// ---------------------------------------------------------------------------
// Clock governor package
// Constants, shared types and helpers for the governor core.
// ---------------------------------------------------------------------------
package ercg_pkg;

  localparam int STEP_COUNT = 64;
  localparam int STEP_W     = 6;
  localparam int PEAK_AW    = 7;
  localparam int Q_W        = 24;
  localparam int CFG_W      = 17;
  localparam int DIV_NW     = 40;
  localparam int DIV_DW     = 24;
  localparam int DIV_CW     = 6;
  localparam int MUL_W      = 26;

  localparam logic [Q_W-1:0]   SAT24        = 24'hFFFFFF;
  localparam logic [CFG_W-1:0] DECAY_Q16    = 17'd65208;
  localparam logic [CFG_W-1:0] Q_ONE        = 17'd65536;
  localparam logic [Q_W-1:0]   WEIGHT_FULL  = 24'd6553600;
  localparam logic [Q_W-1:0]   WEIGHT_TRUST = 24'd9830400;
  localparam logic [STEP_W:0]  EXTRAP_SPAN  = 7'd20;
  localparam logic [Q_W-1:0]   RATE_DIV     = 24'd100;

  typedef enum logic [2:0] {
    CFG_DEFAULT_STEP,
    CFG_TOP_STEP,
    CFG_RATE_CEILING,
    CFG_STAY_BONUS,
    CFG_OVERHEAT
  } cfg_idx_e;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quotient;
  } div_rsp_t;

  function automatic logic [STEP_W-1:0] clamp_step(logic [STEP_W-1:0] s);
    return (s > STEP_W'(STEP_COUNT - 1)) ? STEP_W'(STEP_COUNT - 1) : s;
  endfunction

endpackage

// ===== rtl/error_rate_clock_governor_core.sv =====
// A poll result passes through states P0, P1 and P2 to the done state, which loads the output
// register once out_stall_i lets it. End of scan: the rate divide, extrapolation for each step
// below top_step with a divide for each peak extrapolated by division, the two reach searches
// and the score loop over the candidate steps.
// One item at a time; stall is high while busy. Reset: asynchronous, active low; tables
// read as zero via per-entry valid bits, config registers return to their reset values.
// ---------------------------------------------------------------------------
// Error-rate clock governor
// Sequencer around one shared multiplier and one shared divider.
// ---------------------------------------------------------------------------
`include "error_rate_clock_governor_core_macros.svh"

module error_rate_clock_governor_core import ercg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              func_i,
  input  logic              check_failed_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [STEP_W-1:0] clock_step_o,
  output logic              step_changed_o,
  output logic              shutdown_o,
  output logic [Q_W-1:0]    scan_error_rate_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_P0, S_P1, S_P2,
    S_E0, S_E1, S_E2, S_E3, S_E4, S_E5, S_E6, S_E7, S_E8,
    S_R0, S_R1, S_R2, S_R3,
    S_B0, S_B1, S_B2, S_B3,
    S_O0, S_O1, S_O2, S_O3, S_O4,
    S_DONE
  } state_e;

  state_e state_q;

  logic [STEP_W-1:0] dflt_q, top_q, cur_q;
  logic [CFG_W-1:0]  ceil_q, bonus_q, frac_q;
  logic [15:0]       polls_q, errs_q;
  logic [Q_W-1:0]    w_q, pk_q, rate_q, pi_q, nx_q, new_q;
  logic [30:0]       lhs_q;
  logic              upd_q, changed_q, shut_q;
  logic [STEP_W-1:0] idx_q, reach_q, best_q;
  logic signed [2*MUL_W-1:0] bscore_q, mul_p_q;

  logic                out_valid_q, out_changed_q, out_shut_q;
  logic [STEP_W-1:0]   out_step_q;
  logic [Q_W-1:0]      out_rate_q;

  logic [STEP_W-1:0] cur, dflt, top;
  assign cur  = clamp_step(cur_q);
  assign dflt = clamp_step(dflt_q);
  assign top  = clamp_step(top_q);

  // tables
  logic [Q_W-1:0]       tally_mem  [STEP_COUNT];
  logic [Q_W-1:0]       weight_mem [STEP_COUNT];
  logic [Q_W-1:0]       peak_mem   [STEP_COUNT+1];
  logic [STEP_COUNT-1:0] tally_vld_q, weight_vld_q;
  logic [STEP_COUNT:0]   peak_vld_q;
  logic [Q_W-1:0]       tally_rq, weight_rq, peak_rq;
  logic                 tally_rv_q, weight_rv_q, peak_rv_q;
  logic [Q_W-1:0]       tally_rd, weight_rd, peak_rd;

  logic                 tally_we, weight_we, peak_we;
  logic [STEP_W-1:0]    tally_wa, weight_wa, weight_ra;
  logic [PEAK_AW-1:0]   peak_wa, peak_ra;
  logic [Q_W-1:0]       tally_wd, weight_wd, peak_wd;

  logic signed [MUL_W-1:0] mul_a, mul_b;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [32:0]       t_sum;
  logic [Q_W-1:0]    t_new, div_sat, decayed;
  logic [Q_W:0]      w_sum;
  logic [30:0]       rhs;
  logic [15:0]       polls_inc;
  logic              in_acc;

  assign tally_rd  = tally_rv_q  ? tally_rq  : '0;
  assign weight_rd = weight_rv_q ? weight_rq : '0;
  assign peak_rd   = peak_rv_q   ? peak_rq   : '0;

  always_ff @(posedge clk_i) begin
    if (tally_we)  tally_mem[tally_wa]   <= tally_wd;
    if (weight_we) weight_mem[weight_wa] <= weight_wd;
    if (peak_we)   peak_mem[peak_wa]     <= peak_wd;
    tally_rq  <= tally_mem[cur];
    weight_rq <= weight_mem[weight_ra];
    peak_rq   <= peak_mem[peak_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tally_vld_q  <= '0;
      weight_vld_q <= '0;
      peak_vld_q   <= '0;
      tally_rv_q   <= 1'b0;
      weight_rv_q  <= 1'b0;
      peak_rv_q    <= 1'b0;
    end else begin
      if (tally_we)  tally_vld_q[tally_wa]   <= 1'b1;
      if (weight_we) weight_vld_q[weight_wa] <= 1'b1;
      if (peak_we)   peak_vld_q[peak_wa]     <= 1'b1;
      tally_rv_q  <= tally_vld_q[cur];
      weight_rv_q <= weight_vld_q[weight_ra];
      peak_rv_q   <= peak_vld_q[peak_ra];
    end
  end

  ercg_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign t_sum   = {9'b0, tally_rd} + {1'b0, errs_q, 16'b0};
  assign t_new   = (t_sum > {9'b0, SAT24}) ? SAT24 : t_sum[Q_W-1:0];
  assign div_sat = (div_rsp.quotient > DIV_NW'(SAT24)) ? SAT24 : div_rsp.quotient[Q_W-1:0];
  assign decayed = mul_p_q[39:16];
  assign w_sum   = {1'b0, decayed} + (Q_W+1)'(Q_ONE);
  assign rhs     = mul_p_q[30:0];
  assign polls_inc = (polls_q != 16'hFFFF) ? polls_q + 16'd1 : polls_q;

  // memory ports, shared multiplier operands, divider request
  always_comb begin
    tally_we  = 1'b0;
    tally_wa  = cur;
    tally_wd  = t_new;
    weight_we = 1'b0;
    weight_wa = cur;
    weight_wd = w_sum[Q_W] ? SAT24 : w_sum[Q_W-1:0];
    weight_ra = cur;
    peak_we   = 1'b0;
    peak_wa   = {1'b0, cur};
    peak_wd   = div_sat;
    peak_ra   = {1'b0, cur};
    mul_a     = '0;
    mul_b     = '0;
    div_req   = '0;
    unique case (state_q)
      S_P0: begin
        mul_a = {2'b0, tally_rd};
        mul_b = MUL_W'(DECAY_Q16);
      end
      S_P1: begin
        tally_we = 1'b1;
        tally_wd = decayed;
        mul_a    = {2'b0, w_q};
        mul_b    = MUL_W'(DECAY_Q16);
      end
      S_P2: weight_we = 1'b1;
      S_E0: begin
        tally_we         = 1'b1;
        div_req.start    = 1'b1;
        div_req.dividend = (weight_rd < WEIGHT_FULL) ? DIV_NW'(t_new) : {t_new, 16'b0};
        div_req.divisor  = (weight_rd < WEIGHT_FULL) ? RATE_DIV : weight_rd;
      end
      S_E1: peak_we = div_rsp.done && (div_sat > pk_q);
      S_E2: peak_ra = '0;
      S_E3: peak_ra = PEAK_AW'(idx_q) + 1'b1;
      S_E4: begin
        mul_a = {2'b0, peak_rd};
        mul_b = MUL_W'(idx_q);
      end
      S_E5: begin
        mul_a = {2'b0, pi_q};
        mul_b = MUL_W'({1'b0, idx_q} + EXTRAP_SPAN);
      end
      S_E6: begin
        div_req.dividend = DIV_NW'(rhs);
        div_req.divisor  = DIV_DW'(idx_q);
        div_req.start    = (lhs_q < rhs) && (idx_q != '0);
      end
      S_E8: begin
        peak_we = upd_q;
        peak_wa = PEAK_AW'(idx_q) + 1'b1;
        peak_wd = new_q;
        peak_ra = PEAK_AW'(idx_q) + PEAK_AW'(2);
      end
      S_R0: peak_ra = PEAK_AW'(1);
      S_R1: peak_ra = PEAK_AW'(reach_q) + PEAK_AW'(2);
      S_R2: begin
        weight_ra = reach_q;
        peak_ra   = PEAK_AW'(reach_q) + 1'b1;
      end
      S_B0: peak_ra = '0;
      S_B1: begin
        mul_a = MUL_W'({({1'b0, idx_q} + 1'b1), 16'b0})
              + ((idx_q == cur) ? MUL_W'(bonus_q) : '0);
        mul_b = MUL_W'(Q_ONE) - {2'b0, peak_rd};
      end
      S_B2: peak_ra = PEAK_AW'(idx_q) + 1'b1;
      S_O1: weight_ra = reach_q + 1'b1;
      S_O3: begin
        mul_a = MUL_W'(Q_ONE) - MUL_W'(frac_q);
        mul_b = MUL_W'(reach_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_p_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      dflt_q        <= '0;
      top_q         <= STEP_W'(63);
      ceil_q        <= CFG_W'(3277);
      bonus_q       <= CFG_W'(6554);
      frac_q        <= CFG_W'(26214);
      cur_q         <= '0;
      polls_q       <= '0;
      errs_q        <= '0;
      out_valid_q   <= 1'b0;
      w_q <= '0; pk_q <= '0; rate_q <= '0; pi_q <= '0; nx_q <= '0; new_q <= '0;
      lhs_q <= '0; upd_q <= 1'b0; changed_q <= 1'b0; shut_q <= 1'b0;
      idx_q <= '0; reach_q <= '0; best_q <= '0; bscore_q <= '0;
      out_step_q <= '0; out_changed_q <= 1'b0; out_shut_q <= 1'b0; out_rate_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DEFAULT_STEP: dflt_q  <= cfg_data_i[STEP_W-1:0];
          CFG_TOP_STEP:     top_q   <= cfg_data_i[STEP_W-1:0];
          CFG_RATE_CEILING: ceil_q  <= cfg_data_i;
          CFG_STAY_BONUS:   bonus_q <= cfg_data_i;
          CFG_OVERHEAT:     frac_q  <= cfg_data_i;
          default: ;
        endcase
      end
      // the done state reloads the output register itself
      if (out_valid_q && !out_stall_i && state_q != S_DONE) out_valid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: if (in_acc) begin
          changed_q <= 1'b0;
          shut_q    <= 1'b0;
          rate_q    <= '0;
          if (!func_i) begin
            polls_q <= polls_inc;
            // errors count from the third poll of a scan
            if (check_failed_i && polls_inc > 16'd2 && errs_q != 16'hFFFF)
              errs_q <= errs_q + 16'd1;
            state_q <= S_P0;
          end else begin
            state_q <= S_E0;
          end
        end
        S_P0: begin
          w_q     <= weight_rd;
          state_q <= S_P1;
        end
        S_P1: state_q <= S_P2;
        S_P2: state_q <= S_DONE;
        S_E0: begin
          pk_q    <= peak_rd;
          polls_q <= '0;
          errs_q  <= '0;
          state_q <= S_E1;
        end
        S_E1: if (div_rsp.done) begin
          rate_q  <= div_sat;
          idx_q   <= '0;
          state_q <= (top == '0) ? S_R0 : S_E2;
        end
        S_E2: state_q <= S_E3;
        S_E3: begin
          pi_q    <= peak_rd;
          state_q <= S_E4;
        end
        S_E4: begin
          nx_q    <= peak_rd;
          state_q <= S_E5;
        end
        S_E5: begin
          lhs_q   <= mul_p_q[30:0];
          state_q <= S_E6;
        end
        S_E6: begin
          if (lhs_q < rhs) begin
            upd_q <= 1'b1;
            if (idx_q == '0) begin
              // peak of step zero drives step one to saturation
              new_q   <= SAT24;
              state_q <= S_E8;
            end else begin
              state_q <= S_E7;
            end
          end else begin
            upd_q   <= 1'b0;
            new_q   <= nx_q;
            state_q <= S_E8;
          end
        end
        S_E7: if (div_rsp.done) begin
          new_q   <= div_sat;
          state_q <= S_E8;
        end
        S_E8: begin
          pi_q    <= new_q;
          idx_q   <= idx_q + 1'b1;
          state_q <= ({1'b0, idx_q} + 1'b1 < {1'b0, top}) ? S_E4 : S_R0;
        end
        S_R0: begin
          reach_q <= '0;
          state_q <= (dflt != '0) ? S_R1 : S_R2;
        end
        S_R1: begin
          if (peak_rd < Q_W'(ceil_q)) begin
            reach_q <= reach_q + 1'b1;
            state_q <= ({1'b0, reach_q} + 1'b1 < {1'b0, dflt}) ? S_R1 : S_R2;
          end else begin
            state_q <= S_R2;
          end
        end
        S_R2: state_q <= (reach_q < top) ? S_R3 : S_B0;
        S_R3: begin
          if (weight_rd > WEIGHT_TRUST && peak_rd < Q_W'(ceil_q)) begin
            reach_q <= reach_q + 1'b1;
            state_q <= S_R2;
          end else begin
            state_q <= S_B0;
          end
        end
        S_B0: begin
          idx_q    <= '0;
          best_q   <= '0;
          bscore_q <= '0;
          state_q  <= S_B1;
        end
        S_B1: state_q <= S_B2;
        S_B2: begin
          if (mul_p_q > bscore_q) begin
            best_q   <= idx_q;
            bscore_q <= mul_p_q;
          end
          if (idx_q < reach_q) begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_B1;
          end else begin
            state_q <= S_B3;
          end
        end
        S_B3: begin
          changed_q <= (best_q != cur);
          cur_q     <= best_q;
          state_q   <= S_O0;
        end
        S_O0: begin
          reach_q <= dflt;
          state_q <= S_O1;
        end
        S_O1: state_q <= (reach_q < top) ? S_O2 : S_O3;
        S_O2: begin
          if (weight_rd > WEIGHT_FULL) begin
            reach_q <= reach_q + 1'b1;
            state_q <= S_O1;
          end else begin
            state_q <= S_O3;
          end
        end
        S_O3: state_q <= S_O4;
        S_O4: begin
          shut_q  <= ($signed({20'b0, best_q, 16'b0}) < mul_p_q) &&
                     ($signed({2'b0, best_q}) < $signed({2'b0, reach_q}) - 8'sd1);
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q   <= 1'b1;
            out_step_q    <= cur_q;
            out_changed_q <= changed_q;
            out_shut_q    <= shut_q;
            out_rate_q    <= rate_q;
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign clock_step_o      = out_step_q;
  assign step_changed_o    = out_changed_q;
  assign shutdown_o        = out_shut_q;
  assign scan_error_rate_o = out_rate_q;

  `ERCG_ASSERT_NOW(a_div_done_waited, div_rsp.done, (state_q == S_E1 || state_q == S_E7), "divider beat with no waiting state")
  `ERCG_ASSERT_NEXT(a_poll_path, in_acc && !func_i, state_q == S_P0, "poll beat did not enter poll path")
  `ERCG_ASSERT_NOW(a_extrap_bound, state_q == S_E4, idx_q < top, "extrapolation index past top step")

endmodule

// ===== rtl/ercg_div.sv =====
// ---------------------------------------------------------------------------
// Iterative divider
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module ercg_div import ercg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q, done_q;
  logic [DIV_CW-1:0] cnt_q;
  logic [DIV_DW:0]   rem_q;
  logic [DIV_NW-1:0] quo_q;
  logic [DIV_DW-1:0] dvs_q;
  logic [DIV_DW:0]   rem_sh;
  logic              fits;

  assign rem_sh = {rem_q[DIV_DW-1:0], quo_q[DIV_NW-1]};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CW'(DIV_NW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= fits ? rem_sh - {1'b0, dvs_q} : rem_sh;
      quo_q <= {quo_q[DIV_NW-2:0], fits};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule
